// File: rtl/lz4d_pkg.sv
package lz4d_pkg;

  localparam int unsigned HistDepth = 65536;
  localparam int unsigned CntW      = 17;
  localparam int unsigned LitW      = 17;
  localparam int unsigned MatchW    = 18;

  localparam logic [CntW-1:0]   CapLimit = 17'h10000;
  localparam logic [LitW-1:0]   LitSat   = 17'h1FFFF;
  localparam logic [MatchW-1:0] MatchSat = 18'h3FFFF;
  localparam logic [3:0]        NibMax   = 4'hF;
  localparam logic [7:0]        ExtMore  = 8'hFF;
  localparam logic [MatchW-1:0] MinMatch = 18'd4;

  typedef enum logic [2:0] {
    StData   = 3'd0,
    StDone   = 3'd1,
    StTrunc  = 3'd2,
    StOffset = 3'd3,
    StCap    = 3'd4,
    StBusy   = 3'd5
  } lz4d_status_e;

  typedef enum logic [7:0] {
    PhToken    = 8'b0000_0001,
    PhLitExt   = 8'b0000_0010,
    PhLit      = 8'b0000_0100,
    PhOffLo    = 8'b0000_1000,
    PhOffHi    = 8'b0001_0000,
    PhMatchExt = 8'b0010_0000,
    PhCopy     = 8'b0100_0000,
    PhSkip     = 8'b1000_0000
  } lz4d_phase_e;

  // per-word decision handed from the parser to the output pipeline
  typedef struct packed {
    logic         res;
    logic         wr;
    logic         drain;
    lz4d_status_e status;
    logic         last;
    logic         pend;
    logic [7:0]   data;
  } lz4d_item_t;

endpackage

// File: rtl/lz4d_ram.sv
module lz4d_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lz4d_ctrl.sv
module lz4d_ctrl #(
  parameter int unsigned HISTORY_DEPTH = lz4d_pkg::HistDepth,
  localparam int unsigned AW = $clog2(HISTORY_DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 acc_i,
  input  logic                 op_i,
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  input  logic                 cfg_we_i,
  input  logic [16:0]          cfg_wdata_i,
  output lz4d_pkg::lz4d_item_t item_o,
  output logic [AW-1:0]        rd_addr_o,
  output logic [AW-1:0]        wr_addr_o
);
  import lz4d_pkg::*;

  localparam logic [CntW-1:0] DepthW   = CntW'(HISTORY_DEPTH);
  localparam logic [AW-1:0]   PtrLast  = AW'(HISTORY_DEPTH - 1);

  lz4d_phase_e       phase_q, phase_d;
  logic [CntW-1:0]   out_count_q, out_count_d;
  logic [LitW-1:0]   literal_left_q, literal_left_d;
  logic [MatchW-1:0] match_left_q, match_left_d;
  logic [15:0]       match_offset_q, match_offset_d;
  logic [3:0]        match_code_q, match_code_d;
  logic [AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]   out_capacity_q;

  logic [CntW-1:0]   cap;
  logic [LitW:0]     lit_ext_sum;
  logic [LitW-1:0]   lit_ext_sat, lit_len;
  logic [MatchW:0]   match_ext_sum;
  logic [MatchW-1:0] match_ext_sat, match_total;
  logic [15:0]       match_off;
  logic              lit_over, match_over, off_bad;
  logic [CntW-1:0]   ptr_w, off_w, rd_w;

  assign cap = (out_capacity_q > CapLimit) ? CapLimit : out_capacity_q;

  assign lit_ext_sum = {1'b0, literal_left_q} + (LitW+1)'(byte_i);
  assign lit_ext_sat = (lit_ext_sum > {1'b0, LitSat}) ? LitSat : lit_ext_sum[LitW-1:0];
  assign lit_len     = (phase_q == PhToken) ? LitW'(byte_i[7:4]) : lit_ext_sat;
  assign lit_over    = ({1'b0, out_count_q} + {1'b0, lit_len}) > (LitW+1)'(cap);

  assign match_ext_sum = {1'b0, match_left_q} + (MatchW+1)'(byte_i);
  assign match_ext_sat = (match_ext_sum > {1'b0, MatchSat}) ? MatchSat
                                                            : match_ext_sum[MatchW-1:0];
  assign match_total = (phase_q == PhOffHi) ? (MatchW'(match_code_q) + MinMatch)
                                            : match_ext_sat;
  assign match_off  = (phase_q == PhOffHi) ? {byte_i, match_offset_q[7:0]} : match_offset_q;
  assign match_over = ((MatchW+1)'(out_count_q) + {1'b0, match_total}) > (MatchW+1)'(cap);
  assign off_bad    = (match_off == 16'd0) || (CntW'(match_off) > out_count_q) ||
                      (CntW'(match_off) > DepthW);

  // history entry behind the write pointer, wrapped at the store depth
  assign ptr_w = CntW'(wr_ptr_q);
  assign off_w = CntW'(match_offset_q);
  assign rd_w  = (ptr_w >= off_w) ? (ptr_w - off_w) : (ptr_w + DepthW - off_w);
  assign rd_addr_o = rd_w[AW-1:0];
  assign wr_addr_o = wr_ptr_q;

  always_comb begin
    logic             fail_en;
    logic             fail_last;
    lz4d_status_e     fail_st;
    logic             nb;
    logic             keep;

    phase_d        = phase_q;
    out_count_d    = out_count_q;
    literal_left_d = literal_left_q;
    match_left_d   = match_left_q;
    match_offset_d = match_offset_q;
    match_code_d   = match_code_q;
    wr_ptr_d       = wr_ptr_q;
    item_o         = '{res: 1'b0, wr: 1'b0, drain: 1'b0, status: StData,
                       last: 1'b0, pend: 1'b0, data: 8'd0};
    fail_en   = 1'b0;
    fail_last = 1'b0;
    fail_st   = StData;
    nb        = 1'b0;
    keep      = 1'b0;

    if (op_i) begin
      if (phase_q == PhCopy) begin
        keep         = 1'b1;
        item_o.res   = 1'b1;
        item_o.drain = 1'b1;
        item_o.pend  = (match_left_q != MatchW'(1));
        match_left_d = match_left_q - MatchW'(1);
        if (match_left_q == MatchW'(1)) begin
          phase_d = PhToken;
        end
      end
    end else begin
      case (phase_q)
        PhToken: begin
          literal_left_d = LitW'(byte_i[7:4]);
          match_code_d   = byte_i[3:0];
          if (last_i) begin
            if (byte_i[7:4] == 4'd0) begin
              nb            = 1'b1;
              item_o.res    = 1'b1;
              item_o.status = StDone;
              item_o.last   = 1'b1;
            end else begin
              fail_en = 1'b1; fail_st = StTrunc; fail_last = 1'b1;
            end
          end else if (byte_i[7:4] == NibMax) begin
            phase_d = PhLitExt;
          end else if (lit_over) begin
            fail_en = 1'b1; fail_st = StCap;
          end else begin
            phase_d = (lit_len != '0) ? PhLit : PhOffLo;
          end
        end
        PhLitExt: begin
          if (last_i) begin
            fail_en = 1'b1; fail_st = StTrunc; fail_last = 1'b1;
          end else begin
            literal_left_d = lit_ext_sat;
            if (byte_i != ExtMore) begin
              if (lit_over) begin
                fail_en = 1'b1; fail_st = StCap;
              end else begin
                phase_d = (lit_len != '0) ? PhLit : PhOffLo;
              end
            end
          end
        end
        PhLit: begin
          if (last_i && literal_left_q != LitW'(1)) begin
            fail_en = 1'b1; fail_st = StTrunc; fail_last = 1'b1;
          end else begin
            keep           = 1'b1;
            literal_left_d = literal_left_q - LitW'(1);
            item_o.res     = 1'b1;
            item_o.data    = byte_i;
            item_o.last    = last_i;
            if (last_i) begin
              nb = 1'b1;
            end else if (literal_left_q == LitW'(1)) begin
              phase_d = PhOffLo;
            end
          end
        end
        PhOffLo: begin
          if (last_i) begin
            fail_en = 1'b1; fail_st = StTrunc; fail_last = 1'b1;
          end else begin
            match_offset_d = {8'd0, byte_i};
            phase_d        = PhOffHi;
          end
        end
        PhOffHi, PhMatchExt: begin
          if (last_i) begin
            fail_en = 1'b1; fail_st = StTrunc; fail_last = 1'b1;
          end else begin
            match_offset_d = match_off;
            match_left_d   = match_total;
            if ((phase_q == PhOffHi && match_code_q == NibMax) ||
                (phase_q == PhMatchExt && byte_i == ExtMore)) begin
              phase_d = PhMatchExt;
            end else if (off_bad) begin
              fail_en = 1'b1; fail_st = StOffset;
            end else if (match_over) begin
              fail_en = 1'b1; fail_st = StCap;
            end else begin
              phase_d = PhCopy;
            end
          end
        end
        PhCopy: begin
          fail_en = 1'b1; fail_st = StBusy; fail_last = last_i;
        end
        PhSkip: begin
          if (last_i) begin
            nb = 1'b1;
          end
        end
        default: begin
          nb = 1'b1;
        end
      endcase
    end

    if (keep) begin
      out_count_d = out_count_q + CntW'(1);
      wr_ptr_d    = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + AW'(1);
    end
    item_o.wr = keep;

    if (fail_en) begin
      nb            = 1'b1;
      item_o.res    = 1'b1;
      item_o.status = fail_st;
      item_o.last   = 1'b1;
      item_o.pend   = 1'b0;
      item_o.data   = 8'd0;
    end

    // start over: a failure that is not on the closing word drops the rest
    if (nb) begin
      phase_d        = (fail_en && !fail_last) ? PhSkip : PhToken;
      out_count_d    = '0;
      literal_left_d = '0;
      match_left_d   = '0;
      wr_ptr_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhToken;
      out_count_q    <= '0;
      literal_left_q <= '0;
      match_left_q   <= '0;
      match_offset_q <= '0;
      match_code_q   <= '0;
      wr_ptr_q       <= '0;
    end else if (acc_i) begin
      phase_q        <= phase_d;
      out_count_q    <= out_count_d;
      literal_left_q <= literal_left_d;
      match_left_q   <= match_left_d;
      match_offset_q <= match_offset_d;
      match_code_q   <= match_code_d;
      wr_ptr_q       <= wr_ptr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_capacity_q <= CapLimit;
    end else if (cfg_we_i) begin
      out_capacity_q <= cfg_wdata_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhCopy) |-> (match_left_q != '0))
    else $error("copy phase with no match bytes left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_count_q <= CapLimit)
    else $error("output count beyond capacity limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && !op_i && phase_q == PhCopy) |=>
      (phase_q == PhToken || phase_q == PhSkip))
    else $error("byte during copy did not abort the block");

endmodule

// File: rtl/lz4_block_decompressor.sv
// Pipeline: an accepted word is held in the item register while the history is read,
// then in the output register; offset-one copies are forwarded.
// Throughput: one word per cycle, compressed bytes and drain steps alike, while the output
// is not stalled; each literal or copied byte takes the single history write port once.
// Reset: parser returns to waiting for a token, capacity to 65536, pipeline empties;
// the history memory is not cleared and needs no sweep.
module lz4_block_decompressor #(
  parameter int unsigned HISTORY_DEPTH = lz4d_pkg::HistDepth,
  localparam int unsigned AW = $clog2(HISTORY_DEPTH)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  status_o,
  output logic        out_last_o,
  output logic        copy_pending_o
);
  import lz4d_pkg::*;

  logic           accept, p_move;
  lz4d_item_t     item;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic [7:0]     ram_rdata, p_data;

  logic           p_valid_q;
  lz4d_item_t     p_item_q;
  logic [AW-1:0]  p_wr_addr_q;
  logic           p_fwd_q;
  logic [7:0]     p_fwd_data_q;
  logic           fwd_hit;

  logic           o_valid_q;
  logic [7:0]     o_byte_q;
  lz4d_status_e   o_status_q;
  logic           o_last_q;
  logic           o_pend_q;

  assign p_move     = p_valid_q && (!o_valid_q || !out_stall_i);
  assign in_stall_o = p_valid_q && o_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  lz4d_ctrl #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .acc_i       (accept),
    .op_i,
    .byte_i      (in_byte_i),
    .last_i      (in_last_i),
    .cfg_we_i,
    .cfg_wdata_i,
    .item_o      (item),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr)
  );

  lz4d_ram #(
    .Width(8),
    .Depth(HISTORY_DEPTH)
  ) u_hist (
    .clk_i,
    .we_i    (p_move && p_item_q.wr),
    .waddr_i (p_wr_addr_q),
    .wdata_i (p_data),
    .re_i    (accept && item.drain),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // the word ahead writes its entry on the same edge this read is taken: forward it
  assign fwd_hit = p_valid_q && p_item_q.wr && (rd_addr == p_wr_addr_q);

  assign p_data = !p_item_q.drain ? p_item_q.data :
                  p_fwd_q         ? p_fwd_data_q  : ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        p_valid_q <= item.res;
      end else if (p_move) begin
        p_valid_q <= 1'b0;
      end
      if (p_move) begin
        o_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_item_q     <= item;
      p_wr_addr_q  <= wr_addr;
      p_fwd_q      <= fwd_hit;
      p_fwd_data_q <= p_data;
    end
    if (p_move) begin
      o_byte_q   <= p_data;
      o_status_q <= p_item_q.status;
      o_last_q   <= p_item_q.last;
      o_pend_q   <= p_item_q.pend;
    end
  end

  assign out_valid_o    = o_valid_q;
  assign out_byte_o     = o_byte_q;
  assign status_o       = o_status_q;
  assign out_last_o     = o_last_q;
  assign copy_pending_o = o_pend_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item.drain && fwd_hit) |=> p_fwd_q)
    else $error("history read colliding with pending write not forwarded");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_status_q != StData) |-> (o_last_q && o_byte_q == 8'd0))
    else $error("status word without last flag or with data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_pend_q) |-> (o_status_q == StData && !o_last_q))
    else $error("copy pending on a non-data or closing word");

endmodule
